// ===== design/msof_pkg.sv =====
package msof_pkg;

   // widths fixed by the item and register formats
   localparam int SAMPLE_W    = 16;
   localparam int CHANNEL_W   = 3;
   localparam int COEFF_W     = 32;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 4;
   localparam int STATE_W     = 48;
   localparam int PROD_W      = COEFF_W + SAMPLE_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int MAX_CHANNELS_DEF = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_ONE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_TWO   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CH_COUNT = 3'd4;

   // numerator patterns
   localparam logic [MODE_W-1:0] MODE_LOW_PASS   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIGH_PASS  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DERIVATIVE = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [COEFF_W-1:0] gain;
      logic signed [COEFF_W-1:0] fb_one;
      logic signed [COEFF_W-1:0] fb_two;
      logic [COUNT_W-1:0]        count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_B,
      ST_ROUND,
      ST_MUL_A1,
      ST_MUL_A2,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_GAIN,
      MUL_FB1,
      MUL_FB2
   } mul_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        round_en;
      logic        z1_en;
      logic        finish;
   } cmd_type;

   // saturate a 51-bit signed sum to the 48-bit state range
   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [STATE_W+2:0] v);
      logic signed [STATE_W-1:0] r;
      if (v[STATE_W+2:STATE_W-1] == '0 || v[STATE_W+2:STATE_W-1] == '1) begin
         r = v[STATE_W-1:0];
      end else if (v[STATE_W+2]) begin
         r = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(STATE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== design/msof_csr.sv =====
module msof_csr import msof_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE:     cfg_in.mode   = csr_data[MODE_W-1:0];
            REG_GAIN:     cfg_in.gain   = $signed(csr_data[COEFF_W-1:0]);
            REG_FB_ONE:   cfg_in.fb_one = $signed(csr_data[COEFF_W-1:0]);
            REG_FB_TWO:   cfg_in.fb_two = $signed(csr_data[COEFF_W-1:0]);
            REG_CH_COUNT: cfg_in.count  = csr_data[COUNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_LOW_PASS;
         cfg_ff.gain   <= '0;
         cfg_ff.fb_one <= '0;
         cfg_ff.fb_two <= '0;
         cfg_ff.count  <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/msof_ctrl.sv =====
module msof_ctrl import msof_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      accept;

   // output register can take a new item
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL_B;
         ST_MUL_B:  state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_MUL_A1;
         ST_MUL_A1: state_in = ST_MUL_A2;
         ST_MUL_A2: state_in = ST_WRITE;
         ST_WRITE:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall    = 1'b1;
      cmd.capture  = 1'b0;
      cmd.mul_sel  = MUL_NONE;
      cmd.round_en = 1'b0;
      cmd.z1_en    = 1'b0;
      cmd.finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_MUL_B:  cmd.mul_sel = MUL_GAIN;
         ST_ROUND:  cmd.round_en = 1'b1;
         ST_MUL_A1: cmd.mul_sel = MUL_FB1;
         ST_MUL_A2: begin
            cmd.mul_sel = MUL_FB2;
            cmd.z1_en   = 1'b1;
         end
         ST_WRITE:  cmd.finish = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL_B) else $error("accepted item did not start");

   a_result_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WRITE)
      else $error("result appeared outside write step");

   a_write_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && !out_free) |=> state_ff == ST_WRITE && rsp_valid_ff)
      else $error("write step left while output busy");

endmodule

// ===== design/msof_datapath.sv =====
module msof_datapath import msof_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  cmd_type                    cmd,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic [CHANNEL_W-1:0]       rsp_channel
);

   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_MW = $clog2(MAX_CHANNELS + 1);
   localparam int CNT_W  = (CNT_MW > COUNT_W) ? CNT_MW : COUNT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHANNELS);
   localparam logic signed [STATE_W+1:0] ROUND_BIAS = (STATE_W+2)'(64'sd8388608);
   localparam logic signed [25:0] Y_MAX = 26'sd32767;
   localparam logic signed [25:0] Y_MIN = -26'sd32768;

   // channel counter
   logic [CH_W-1:0]  ch_ff;
   logic [CH_W-1:0]  ch_in;
   logic [CH_W-1:0]  cur_ch_ff;
   logic [CNT_W-1:0] cnt_raw;
   logic [CNT_W-1:0] count_eff;
   logic [CH_W-1:0]  ch_eff;
   logic [CNT_W-1:0] ch_next;

   // datapath registers
   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [SAMPLE_W-1:0]  y_ff;
   logic signed [SAMPLE_W-1:0]  y_in;
   logic signed [STATE_W+1:0]   p1_ff;
   logic signed [STATE_W+1:0]   p1_in;
   logic signed [STATE_W:0]     p2_ff;
   logic signed [STATE_W:0]     p2_in;
   logic signed [STATE_W-1:0]   z1n_ff;
   logic signed [STATE_W-1:0]   z2n;
   logic signed [SAMPLE_W-1:0]  filtered_ff;
   logic [CHANNEL_W-1:0]        channel_ff;

   // multiplier operands
   logic signed [COEFF_W-1:0]   op_a;
   logic signed [SAMPLE_W-1:0]  op_b;

   // delay state memory, z1 in the upper half
   logic [2*STATE_W-1:0]        mem [MAX_CHANNELS];
   logic [2*STATE_W-1:0]        rd_ff;
   logic                        rd_vld_ff;
   logic [MAX_CHANNELS-1:0]     valid_ff;
   logic signed [STATE_W-1:0]   z1_rd;
   logic signed [STATE_W-1:0]   z2_rd;

   // rounding
   logic signed [STATE_W+1:0]   acc_round;
   logic signed [25:0]          y_wide;
   logic signed [STATE_W:0]     two_bu;

   // effective count and channel
   always_comb begin
      cnt_raw   = CNT_W'(cfg.count);
      count_eff = cnt_raw;
      if (cnt_raw == '0) count_eff = CNT_W'(1);
      if (cnt_raw > CNT_MAX) count_eff = CNT_MAX;
      ch_eff = ch_ff;
      if (CNT_W'(ch_ff) >= count_eff) ch_eff = '0;
      ch_next = CNT_W'(ch_eff) + CNT_W'(1);
      ch_in   = ch_ff;
      if (cmd.capture) begin
         ch_in = (ch_next >= count_eff) ? '0 : CH_W'(ch_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= '0;
      end else begin
         ch_ff <= ch_in;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample;
         cur_ch_ff <= ch_eff;
      end
   end

   // shared multiplier
   always_comb begin
      op_a = cfg.gain;
      op_b = y_ff;
      case (cmd.mul_sel)
         MUL_GAIN: begin
            op_a = cfg.gain;
            op_b = sample_ff;
         end
         MUL_FB1:  op_a = cfg.fb_one;
         MUL_FB2:  op_a = cfg.fb_two;
         default:  op_a = cfg.gain;
      endcase
      prod_in = op_a * op_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_sel != MUL_NONE) prod_ff <= prod_in;
   end

   // state read, entries never written read as zero
   assign z1_rd = rd_vld_ff ? $signed(rd_ff[2*STATE_W-1:STATE_W]) : '0;
   assign z2_rd = rd_vld_ff ? $signed(rd_ff[STATE_W-1:0]) : '0;

   // output rounding and numerator terms
   always_comb begin
      acc_round = (STATE_W+2)'(prod_ff) + (STATE_W+2)'(z1_rd) + ROUND_BIAS;
      y_wide    = acc_round[STATE_W+1:24];
      if (y_wide > Y_MAX) begin
         y_in = SAMPLE_W'(Y_MAX);
      end else if (y_wide < Y_MIN) begin
         y_in = SAMPLE_W'(Y_MIN);
      end else begin
         y_in = y_wide[SAMPLE_W-1:0];
      end
      two_bu = {prod_ff, 1'b0};
      case (cfg.mode)
         MODE_HIGH_PASS: begin
            p1_in = (STATE_W+2)'(z2_rd);
            p2_in = -(STATE_W+1)'(prod_ff);
         end
         MODE_DERIVATIVE: begin
            p1_in = (STATE_W+2)'(z2_rd) - (STATE_W+2)'(two_bu);
            p2_in = (STATE_W+1)'(prod_ff);
         end
         default: begin
            p1_in = (STATE_W+2)'(z2_rd) + (STATE_W+2)'(two_bu);
            p2_in = (STATE_W+1)'(prod_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         y_ff  <= y_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   // feedback subtraction
   always_ff @(posedge clock) begin
      if (cmd.z1_en) z1n_ff <= sat48((STATE_W+3)'(p1_ff) - (STATE_W+3)'(prod_ff));
   end

   assign z2n = sat48((STATE_W+3)'(p2_ff) - (STATE_W+3)'(prod_ff));

   // delay state memory
   always_ff @(posedge clock) begin
      if (cmd.finish) mem[cur_ch_ff] <= {z1n_ff, z2n};
      rd_ff     <= mem[cur_ch_ff];
      rd_vld_ff <= valid_ff[cur_ch_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.finish) begin
         valid_ff[cur_ch_ff] <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         filtered_ff <= y_ff;
         channel_ff  <= CHANNEL_W'(cur_ch_ff);
      end
   end

   assign rsp_filtered = filtered_ff;
   assign rsp_channel  = channel_ff;

   // checks
   a_entry_marked: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> valid_ff[$past(cur_ch_ff)]) else $error("state entry not marked");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> CNT_W'(cur_ch_ff) < $past(count_eff))
      else $error("channel beyond count");

   a_result_channel: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_channel == CHANNEL_W'($past(cur_ch_ff)))
      else $error("result tagged with wrong channel");

endmodule

// ===== design/multichannel_second_order_filter.sv =====
// items are taken only in idle, one at a time; the write step waits for a
//   free output; the single 32x16 multiplier forms b*u, a1*y and a2*y in
//   turn and the state memory is written once per item
// reset: delay states read as zero, channel counter 0, mode low-pass,
//   coefficients 0, channel count 1; no clearing pass
module multichannel_second_order_filter import msof_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic [CHANNEL_W-1:0]       rsp_channel,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   cfg_type cfg;
   cmd_type cmd;

   // configuration registers
   msof_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // sequencer
   msof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // filter arithmetic and state
   msof_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .req_sample   (req_sample),
      .rsp_filtered (rsp_filtered),
      .rsp_channel  (rsp_channel)
   );

endmodule
